@@ rtl/abrm_pkg.sv @@
// Shared types, constants and helpers for the adaptive binning rate map.
`timescale 1ns / 1ps
package abrm_pkg;

  // Input item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Stop criterion: operands and products saturate at STOP_CAP
  localparam int unsigned CAP_W       = 17;
  localparam int unsigned STOP_CAP    = 65537;
  localparam int unsigned STOP_LIMIT  = 65536;
  localparam int unsigned MIN_OCC_SUM = 10;

  // One cell's stored counts, packed into one memory word
  typedef struct packed {
    logic [15:0] occ;
    logic [15:0] spk;
  } cell_counts_t;

  // Clamp a value to the stop-criterion cap
  function automatic logic [CAP_W-1:0] stop_cap(input logic [63:0] x);
    logic [CAP_W-1:0] res;
    if (x > 64'(STOP_CAP)) begin
      res = CAP_W'(STOP_CAP);
    end else begin
      res = x[CAP_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/abrm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module abrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/abrm_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module abrm_div #(
  parameter int DW = 43,
  parameter int VW = 27
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     shifted;
  logic [VW:0]     diff;
  logic            ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
  end

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/adaptive_binning_rate_map_core.sv @@
// Top level of the adaptive binning rate map: cell store, shell walker and rate divider.
`timescale 1ns / 1ps
// A load beat writes one cell's occupancy and spike counts; loads outside the grid are
// dropped. A query beat walks shells of squared radius 0, 1, 2 and up around the cell and
// reads the cells each shell hits, until the stop test alpha^2*occ^2*r*spikes > 1 passes
// or the last shell is done, then divides spikes by occupancy in the bit-serial divider
// into an unsigned Q16.16 rate. A query outside the grid, on a cell with zero occupancy
// or with an occupancy sum under MIN_OCC_SUM gets rate 0. The walk is bounded by the
// single memory read port and the one shared multiplier in the stop test. The input is
// stalled for the whole query; the result waits in an output register.
module adaptive_binning_rate_map_core
  import abrm_pkg::*;
#(
  parameter int GRID_ROWS       = 144,
  parameter int GRID_COLS       = 96,
  parameter int SQ_RADIUS_LIMIT = 200,
  parameter int MAX_SPAN        = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_row,
  input  logic [6:0]  in_col,
  input  logic [15:0] in_occupancy,
  input  logic [15:0] in_spikes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_row,
  output logic [6:0]  out_col,
  output logic [31:0] out_rate
);

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = $clog2(MAX_SPAN + 2);
  localparam int RW     = $clog2(SQ_RADIUS_LIMIT + 1);
  localparam int CW     = $clog2(GRID_ROWS + GRID_COLS + MAX_SPAN + 1) + 1;
  localparam int SUMW   = 16 + $clog2((2 * MAX_SPAN + 1) * (2 * MAX_SPAN + 1) + 1);
  localparam int QW     = SUMW + 16;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CENTER = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_CELLS  = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // Stop-test product steps
  localparam logic [2:0] M_ALPHA = 3'd0;
  localparam logic [2:0] M_OCC_A = 3'd1;
  localparam logic [2:0] M_OCC_B = 3'd2;
  localparam logic [2:0] M_RAD   = 3'd3;
  localparam logic [2:0] M_SPK   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      alpha_r;
  logic [7:0]       row_r, row_nxt;
  logic [6:0]       col_r, col_nxt;
  logic [RW-1:0]    r_r, r_nxt;
  logic [SW-1:0]    d_r, d_nxt;
  logic [SW-1:0]    s_hit_r, s_hit_nxt;
  logic [1:0]       q_r, q_nxt;
  logic [2:0]       m_r, m_nxt;
  logic [SUMW-1:0]  os_r, os_nxt;
  logic [SUMW-1:0]  ss_r, ss_nxt;
  logic [CAP_W-1:0] prod_r, prod_nxt;
  logic             acc_pend_r, acc_pend_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_row_r, out_row_nxt;
  logic [6:0]       out_col_r, out_col_nxt;
  logic [31:0]      out_rate_r, out_rate_nxt;
  logic [SW-1:0]    sarr_r [0:MAX_SPAN];

  logic             in_inside;
  logic [AW-1:0]    center_addr;
  logic [AW-1:0]    cell_addr;
  logic [AW-1:0]    ram_raddr;
  logic             ram_we;
  cell_counts_t     ram_wdata;
  cell_counts_t     ram_rdata;

  logic [15:0]      d_sq, r_ext, rem, s_sq, s_adj_sq;
  logic             shell_end, hit;
  logic [SW-1:0]    s_cur, s_adj;
  logic             sarr_clear, sarr_wr;

  logic [CW-1:0]    rr, cc;
  logic             skip, ingrid, issue;

  logic [CAP_W-1:0] mul_b;
  logic [2*CAP_W-1:0] prod_full;
  logic [CAP_W-1:0] prod_capped;
  logic             stop;
  logic             last_shell;

  logic             div_start, div_done;
  logic [QW-1:0]    div_quo;
  logic [31:0]      rate_sat;

  // Cell store, both counts in one word
  abrm_ram #(
    .WIDTH($bits(cell_counts_t)),
    .DEPTH(NCELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (center_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Rate divider: (spikes << 16) / occupancy
  abrm_div #(
    .DW(QW),
    .VW(SUMW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({ss_r, 16'd0}),
    .divisor  (os_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Input cell address and grid check
  always_comb begin
    in_inside   = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
    center_addr = AW'(in_row) * AW'(GRID_COLS) + AW'(in_col);
    ram_wdata   = '{occ: in_occupancy, spk: in_spikes};
  end

  // Shell step: advance this row offset's root and test for a hit
  always_comb begin
    d_sq      = 16'(d_r) * 16'(d_r);
    r_ext     = 16'(r_r);
    shell_end = (d_r > SW'(MAX_SPAN)) || (d_sq > r_ext);
    s_cur     = shell_end ? '0 : sarr_r[d_r];
    rem       = r_ext - d_sq;
    s_sq      = 16'(s_cur) * 16'(s_cur);
    if ((s_sq < rem) && (s_cur <= SW'(MAX_SPAN))) begin
      s_adj = s_cur + 1'b1;
    end else begin
      s_adj = s_cur;
    end
    s_adj_sq = 16'(s_adj) * 16'(s_adj);
    hit      = !shell_end && (s_adj <= SW'(MAX_SPAN)) && (s_adj_sq == rem);
  end

  // Neighbor cell for the current sign combination
  always_comb begin
    skip   = (q_r[0] && (d_r == '0)) || (q_r[1] && (s_hit_r == '0));
    rr     = CW'(row_r) + (q_r[0] ? -CW'(d_r) : CW'(d_r));
    cc     = CW'(col_r) + (q_r[1] ? -CW'(s_hit_r) : CW'(s_hit_r));
    ingrid = !rr[CW-1] && !cc[CW-1] && (rr < CW'(GRID_ROWS)) && (cc < CW'(GRID_COLS));
    issue  = !skip && ingrid;
    cell_addr = AW'(rr) * AW'(GRID_COLS) + AW'(cc);
  end

  // Shared multiplier for the stop test
  always_comb begin
    case (m_r)
      M_ALPHA: mul_b = {1'b0, alpha_r};
      M_OCC_A: mul_b = stop_cap(64'(os_r));
      M_OCC_B: mul_b = stop_cap(64'(os_r));
      M_RAD:   mul_b = stop_cap(64'(r_r));
      M_SPK:   mul_b = stop_cap(64'(ss_r));
      default: mul_b = '0;
    endcase
    prod_full   = (2*CAP_W)'(prod_r) * (2*CAP_W)'(mul_b);
    prod_capped = stop_cap(64'(prod_full));
    stop        = (prod_capped > CAP_W'(STOP_LIMIT));
    last_shell  = (r_r == RW'(SQ_RADIUS_LIMIT - 1));
    rate_sat    = (div_quo[QW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    r_nxt         = r_r;
    d_nxt         = d_r;
    s_hit_nxt     = s_hit_r;
    q_nxt         = q_r;
    m_nxt         = m_r;
    os_nxt        = os_r;
    ss_nxt        = ss_r;
    prod_nxt      = prod_r;
    rate_nxt      = rate_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_rate_nxt  = out_rate_r;
    acc_pend_nxt  = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = center_addr;
    div_start     = 1'b0;
    sarr_clear    = 1'b0;
    sarr_wr       = 1'b0;

    // Accumulate the neighbor read issued last cycle
    if (acc_pend_r) begin
      os_nxt = os_r + SUMW'(ram_rdata.occ);
      ss_nxt = ss_r + SUMW'(ram_rdata.spk);
    end

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_LOAD) begin
            ram_we = in_inside;
          end else begin
            row_nxt = in_row;
            col_nxt = in_col;
            if (in_inside) begin
              state_nxt = S_CENTER;
            end else begin
              rate_nxt  = '0;
              state_nxt = S_RESULT;
            end
          end
        end
      end
      S_CENTER: begin
        if (ram_rdata.occ == 16'd0) begin
          rate_nxt  = '0;
          state_nxt = S_RESULT;
        end else begin
          os_nxt     = SUMW'(1);
          ss_nxt     = SUMW'(1);
          r_nxt      = '0;
          d_nxt      = '0;
          sarr_clear = 1'b1;
          state_nxt  = S_STEP;
        end
      end
      S_STEP: begin
        if (shell_end) begin
          // Seed the product with alpha; the first multiply squares it
          prod_nxt  = {1'b0, alpha_r};
          m_nxt     = M_ALPHA;
          state_nxt = S_CHECK;
        end else begin
          sarr_wr = 1'b1;
          if (hit) begin
            s_hit_nxt = s_adj;
            q_nxt     = '0;
            state_nxt = S_CELLS;
          end else begin
            d_nxt = d_r + 1'b1;
          end
        end
      end
      S_CELLS: begin
        ram_raddr    = cell_addr;
        acc_pend_nxt = issue;
        q_nxt        = q_r + 1'b1;
        if (q_r == 2'd3) begin
          d_nxt     = d_r + 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_CHECK: begin
        prod_nxt = prod_capped;
        m_nxt    = m_r + 1'b1;
        if (m_r == M_SPK) begin
          if (stop || last_shell) begin
            if (os_r < SUMW'(MIN_OCC_SUM)) begin
              rate_nxt  = '0;
              state_nxt = S_RESULT;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end else begin
            r_nxt     = r_r + 1'b1;
            d_nxt     = '0;
            state_nxt = S_STEP;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          rate_nxt  = rate_sat;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_rate_nxt  = rate_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= 16'd256;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_pend_r  <= acc_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    r_r        <= r_nxt;
    d_r        <= d_nxt;
    s_hit_r    <= s_hit_nxt;
    q_r        <= q_nxt;
    m_r        <= m_nxt;
    os_r       <= os_nxt;
    ss_r       <= ss_nxt;
    prod_r     <= prod_nxt;
    rate_r     <= rate_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_rate_r <= out_rate_nxt;
  end

  // Per-offset root tracker: clear at query start, advance one entry per step
  always_ff @(posedge clk) begin
    for (int i = 0; i <= MAX_SPAN; i++) begin
      if (sarr_clear) begin
        sarr_r[i] <= '0;
      end else if (sarr_wr && (d_r == SW'(i))) begin
        sarr_r[i] <= s_adj;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_rate  = out_rate_r;

  // Sums start at one and only grow during the walk
  a_sum_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (os_r != '0) && (ss_r != '0))
    else $error("occupancy or spike sum is zero during walk");

  // Divider only runs on a sum that clears the minimum
  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (os_r >= SUMW'(MIN_OCC_SUM)))
    else $error("divider started below minimum occupancy");

  // All neighbor reads have landed before the stop test
  a_no_pend_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> !acc_pend_r)
    else $error("neighbor read pending during stop test");

  // Shell index stays within the radius limit
  a_shell_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (32'(r_r) < SQ_RADIUS_LIMIT))
    else $error("shell index beyond limit");

  // A new result only comes from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_RESULT))
    else $error("result raised outside result state");

endmodule

@@ bench/tb_adaptive_binning_rate_map_core.sv @@
// Self-checking testbench for the adaptive binning rate map core.
`timescale 1ns / 1ps
module tb_adaptive_binning_rate_map_core;
  import abrm_pkg::*;

  localparam int ROWS      = 144;
  localparam int COLS      = 96;
  localparam int SHELLS    = 200;
  localparam int SPAN      = 20;
  localparam int IDLE_MAX  = 40000;
  localparam int PLAN_LEN  = 22;
  localparam int PHASE_LEN = 60;
  localparam int PATCH     = 15;
  localparam int N_CORNER  = 9;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_row;
  logic [6:0]  in_col;
  logic [15:0] in_occupancy;
  logic [15:0] in_spikes;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_row;
  logic [6:0]  out_col;
  logic [31:0] out_rate;

  typedef struct packed {
    logic        mode;
    logic [7:0]  row;
    logic [6:0]  col;
    logic [15:0] occ;
    logic [15:0] spk;
    logic        typed;
    logic [31:0] rate;
  } plan_beat_t;

  typedef struct packed {
    logic [7:0]  row;
    logic [6:0]  col;
    logic [31:0] rate;
  } rate_beat_t;

  // Shadow copy of the cell store, its written marks and the gain register
  logic [15:0] occ_mem [ROWS*COLS];
  logic [15:0] spk_mem [ROWS*COLS];
  bit          loaded_mem [ROWS*COLS];
  logic [15:0] gain;

  rate_beat_t pending_rates[$];
  int fail_count;
  int idle_cycles;
  int n_loads;
  int n_queries;
  int n_checked;
  int n_saturated;

  // Grid corners outside the main patch, each with its two in-grid neighbors
  logic [7:0] corner_rows [N_CORNER] = '{8'd143, 8'd142, 8'd143, 8'd143, 8'd142, 8'd143,
                                         8'd0,   8'd1,   8'd0};
  logic [6:0] corner_cols [N_CORNER] = '{7'd95,  7'd95,  7'd94,  7'd0,   7'd0,   7'd1,
                                         7'd95,  7'd95,  7'd94};

  // Directed beats; expected rates are typed in only for out-of-grid and empty cells
  plan_beat_t plan [PLAN_LEN] = '{
    '{MODE_LOAD,  8'd0,   7'd0,   16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{MODE_QUERY, 8'd0,   7'd0,   16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd143, 7'd95,  16'd1,    16'd0,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd143, 7'd95,  16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd5,   7'd5,   16'd0,    16'hFFFF, 1'b0, 32'd0},
    '{MODE_QUERY, 8'd5,   7'd5,   16'd0,    16'd0,    1'b1, 32'd0},
    '{MODE_LOAD,  8'd255, 7'd127, 16'hFFFF, 16'hFFFF, 1'b0, 32'd0},
    '{MODE_QUERY, 8'd255, 7'd127, 16'hFFFF, 16'hFFFF, 1'b1, 32'd0},
    '{MODE_QUERY, 8'd144, 7'd0,   16'd0,    16'd0,    1'b1, 32'd0},
    '{MODE_QUERY, 8'd0,   7'd96,  16'd0,    16'd0,    1'b1, 32'd0},
    '{MODE_LOAD,  8'd144, 7'd10,  16'd7,    16'd7,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd7,   7'd8,   16'hFFFF, 16'd0,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd7,   7'd8,   16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd9,   7'd10,  16'd1,    16'hFFFF, 1'b0, 32'd0},
    '{MODE_QUERY, 8'd9,   7'd10,  16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd143, 7'd0,   16'd3,    16'hFFFF, 1'b0, 32'd0},
    '{MODE_QUERY, 8'd143, 7'd0,   16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_LOAD,  8'd0,   7'd95,  16'd1,    16'd1,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd0,   7'd95,  16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd3,   7'd12,  16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd12,  7'd2,   16'd0,    16'd0,    1'b0, 32'd0},
    '{MODE_QUERY, 8'd255, 7'd0,   16'd0,    16'd0,    1'b1, 32'd0}
  };

  adaptive_binning_rate_map_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_occupancy (in_occupancy),
    .in_spikes    (in_spikes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_rate     (out_rate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturating product used by the stop test
  function automatic longint unsigned capped_product(longint unsigned a, longint unsigned b);
    longint unsigned p;
    if (a > STOP_CAP) a = STOP_CAP;
    if (b > STOP_CAP) b = STOP_CAP;
    p = a * b;
    return (p > STOP_CAP) ? STOP_CAP : p;
  endfunction

  // Walk shells around the cell and divide the summed counts; flag reads of unloaded cells
  function automatic logic [31:0] binned_rate(int row, int col, output bit clean);
    longint unsigned osum, ssum, q;
    int rad, di, s, rem, rr, cc, k;
    bit done;
    osum  = 1;
    ssum  = 1;
    done  = 1'b0;
    clean = 1'b1;
    if (row >= ROWS || col >= COLS) return 32'd0;
    if (!loaded_mem[row*COLS+col]) clean = 1'b0;
    if (occ_mem[row*COLS+col] == 16'd0) return 32'd0;
    for (rad = 0; rad < SHELLS && !done; rad++) begin
      for (di = -SPAN; di <= SPAN; di++) begin
        if (di * di > rad) continue;
        rem = rad - di * di;
        for (s = 0; s <= SPAN && s * s < rem; s++) ;
        if (s > SPAN || s * s != rem) continue;
        // take +s, and -s when it is a distinct offset
        for (k = 0; k < ((s > 0) ? 2 : 1); k++) begin
          rr = row + di;
          cc = (k == 0) ? col + s : col - s;
          if (rr >= 0 && cc >= 0 && rr < ROWS && cc < COLS) begin
            if (!loaded_mem[rr*COLS+cc]) clean = 1'b0;
            osum += occ_mem[rr*COLS+cc];
            ssum += spk_mem[rr*COLS+cc];
          end
        end
      end
      q = capped_product(gain, gain);
      q = capped_product(q, osum);
      q = capped_product(q, osum);
      q = capped_product(q, rad);
      q = capped_product(q, ssum);
      done = (q > STOP_LIMIT);
    end
    if (osum < MIN_OCC_SUM) return 32'd0;
    q = (ssum << 16) / osum;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // Gap length before a beat: mostly none, some short, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Count pair for a load: mostly tiny so walks run long, sometimes full range
  task automatic pick_counts(output logic [15:0] occ, output logic [15:0] spk);
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) begin
      occ = 16'($urandom_range(0, 3));
      spk = 16'($urandom_range(0, 3));
    end else if (p < 90) begin
      occ = 16'($urandom_range(0, 255));
      spk = 16'($urandom_range(0, 255));
    end else begin
      occ = 16'($urandom_range(0, 65535));
      spk = 16'($urandom_range(0, 65535));
    end
  endtask

  // Drive one input beat, wait for acceptance, and record its effect
  task automatic send_beat(logic mode, logic [7:0] row, logic [6:0] col,
                           logic [15:0] occ, logic [15:0] spk,
                           logic typed, logic [31:0] typed_rate, bit gaps);
    int gap;
    bit clean;
    rate_beat_t exp_beat;
    gap = gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_mode      = mode;
    in_row       = row;
    in_col       = col;
    in_occupancy = occ;
    in_spikes    = spk;
    do @(posedge clk); while (in_stall);
    if (mode == MODE_LOAD) begin
      n_loads++;
      if (row < ROWS && col < COLS) begin
        occ_mem[row*COLS+col]    = occ;
        spk_mem[row*COLS+col]    = spk;
        loaded_mem[row*COLS+col] = 1'b1;
      end
    end else begin
      n_queries++;
      exp_beat.row  = row;
      exp_beat.col  = col;
      exp_beat.rate = binned_rate(row, col, clean);
      if (!clean) begin
        $error("stimulus: query row=%0d col=%0d reads an unloaded cell", row, col);
        fail_count++;
      end
      if (typed) exp_beat.rate = typed_rate;
      if (exp_beat.rate == 32'hFFFF_FFFF) n_saturated++;
      pending_rates.push_back(exp_beat);
    end
  endtask

  // Drain all results, then write the gain while the block is idle
  task automatic write_gain(logic [15:0] value);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    gain = value;
  endtask

  // Random beats: loads and queries in the loaded patch, a few anywhere in the full row and column range
  task automatic random_phase(int count);
    logic [15:0] occ, spk;
    logic [7:0] row;
    logic [6:0] col;
    logic mode;
    bit clean;
    int p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      mode = ($urandom_range(0, 99) < 45) ? MODE_QUERY : MODE_LOAD;
      if (p < 6) begin
        row = 8'($urandom_range(0, 255));
        col = 7'($urandom_range(0, 127));
      end else begin
        row = 8'($urandom_range(0, PATCH - 1));
        col = 7'($urandom_range(0, PATCH - 1));
      end
      // Move a query whose walk would leave the loaded cells to the patch corner
      if (mode == MODE_QUERY) begin
        void'(binned_rate(row, col, clean));
        if (!clean) begin
          row = 8'd0;
          col = 7'd0;
        end
      end
      pick_counts(occ, spk);
      send_beat(mode, row, col, occ, spk, 1'b0, 32'd0, 1'b1);
    end
  endtask

  // Result stall: bursts of random stalling with some clean stretches
  initial begin
    int run;
    int p;
    out_stall = 1'b0;
    forever begin
      p = $urandom_range(0, 99);
      run = $urandom_range(1, 40);
      for (int i = 0; i < run; i++) begin
        @(negedge clk);
        if (p < 30) out_stall = 1'b0;
        else if (p < 90) out_stall = ($urandom_range(0, 2) == 0);
        else out_stall = 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    rate_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rates.size() == 0) begin
        $error("unexpected result beat row=%0d col=%0d rate=%h", out_row, out_col, out_rate);
        fail_count++;
      end else begin
        want = pending_rates.pop_front();
        n_checked++;
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          fail_count++;
        end
        if (out_rate !== want.rate) begin
          $error("out_rate: expected %h, got %h", want.rate, out_rate);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("timeout: no beat for %0d cycles", IDLE_MAX);
        $display("tb_adaptive_binning_rate_map_core: FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [15:0] occ, spk;
    logic [15:0] gains [5];
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 16'd0;
    in_valid     = 1'b0;
    in_mode      = MODE_LOAD;
    in_row       = 8'd0;
    in_col       = 7'd0;
    in_occupancy = 16'd0;
    in_spikes    = 16'd0;
    fail_count   = 0;
    idle_cycles  = 0;
    n_loads      = 0;
    n_queries    = 0;
    n_checked    = 0;
    n_saturated  = 0;
    gain         = 16'd256;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the corner patch that a full walk from the top-left cell can reach
    for (int r = 0; r < PATCH; r++) begin
      for (int c = 0; c < PATCH; c++) begin
        pick_counts(occ, spk);
        send_beat(MODE_LOAD, 8'(r), 7'(c), occ, spk, 1'b0, 32'd0, 1'b0);
      end
    end

    // Fill the other grid corners and their in-grid neighbors
    for (int i = 0; i < N_CORNER; i++) begin
      pick_counts(occ, spk);
      send_beat(MODE_LOAD, corner_rows[i], corner_cols[i], occ, spk, 1'b0, 32'd0, 1'b0);
    end

    // Directed beats at reset gain
    for (int i = 0; i < PLAN_LEN; i++) begin
      send_beat(plan[i].mode, plan[i].row, plan[i].col, plan[i].occ, plan[i].spk,
                plan[i].typed, plan[i].rate, 1'b1);
    end
    random_phase(PHASE_LEN);

    // Walk through gain settings, extremes included
    gains[0] = 16'd0;
    gains[1] = 16'hFFFF;
    gains[2] = 16'd1;
    gains[3] = 16'd16;
    gains[4] = 16'($urandom_range(0, 65535));
    for (int g = 0; g < 5; g++) begin
      write_gain(gains[g]);
      random_phase((g == 0) ? PHASE_LEN / 2 : PHASE_LEN);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d loads and %0d queries over six gain settings", n_loads, n_queries);
    $display("checked %0d rate beats, %0d of them saturated", n_checked, n_saturated);
    if (fail_count == 0) begin
      $display("tb_adaptive_binning_rate_map_core: PASS");
    end else begin
      $display("tb_adaptive_binning_rate_map_core: FAIL");
    end
    $finish;
  end

endmodule
